### rtl/window_3x3_sharpen_blur_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 window filter
// Shared property forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_3X3_SHARPEN_BLUR_FILTER_ASSERT_SVH
`define WINDOW_3X3_SHARPEN_BLUR_FILTER_ASSERT_SVH

// same-cycle implication
`define WFL_ASSERT_SAME(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("wfl assertion failed");

// next-cycle implication
`define WFL_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("wfl assertion failed");

`endif

### rtl/wfl_pkg.sv
// ----------------------------------------------------------------------------
// wfl_pkg
// Types and constants shared by the 3x3 window filter modules.
// ----------------------------------------------------------------------------
package wfl_pkg;

   localparam int CW = 14;
   localparam int PIX_W = 32;
   localparam int NUM_CH = 4;
   localparam int ALPHA_CH = 3;
   localparam logic FILTER_SHARPEN = 1'b0;
   localparam logic FILTER_BLUR = 1'b1;
   localparam logic [13:0] BLUR_RECIP = 14'd7282;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_CHANS = 2'd2;
   localparam logic [1:0] REG_MODE = 2'd3;

   // release kinds, one bit each
   localparam int K_NORM_PREV = 0;
   localparam int K_LAST_PREV = 1;
   localparam int K_NORM_HERE = 2;
   localparam int K_LAST_HERE = 3;

   typedef struct packed {
      logic [CW-1:0] width;
      logic [15:0]   height;
      logic [2:0]    chans;
      logic          mode;
   } cfg_type;

   typedef struct packed {
      logic [2:0][2:0][PIX_W-1:0] win;
      logic [3:0]                 kind;
      logic                       y_ge2;
      logic                       x_eq1;
      logic                       x_eq0;
      logic                       h_one;
   } job_type;

endpackage

### rtl/wfl_front.sv
// ----------------------------------------------------------------------------
// wfl_front
// Tracks raster position, keeps the line buffer and window, classifies releases.
// ----------------------------------------------------------------------------
module wfl_front import wfl_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_frame_start,
   input  logic [PIX_W-1:0] req_pixel,
   output logic             q_valid,
   input  logic             q_ready,
   output job_type          q_job
);

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

   logic [XW-1:0]  col_ff, col_in, x;
   logic [15:0]    row_ff, row_in, y;
   logic           accept, origin, wrap;
   logic [CW-1:0]  x_next;
   logic [16:0]    y_next;
   logic [PIX_W-1:0] pix;

   logic             s1_valid_ff, s1_valid_in, s1_adv;
   logic [XW-1:0]    s1_x_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_yge1_ff, s1_yge2_ff, s1_last_ff, s1_xge1_ff;
   logic             s1_xeq1_ff, s1_xlast_ff, s1_hone_ff;
   logic [2*PIX_W-1:0] rd_ff, wr_data;
   logic [2:0][2:0][PIX_W-1:0] win_ff, win_in;
   logic [3:0]       kind;

   assign accept = req_valid && req_ready;
   assign origin = req_frame_start || (CW'(col_ff) >= cfg.width) || (row_ff >= cfg.height);
   assign x = origin ? '0 : col_ff;
   assign y = origin ? '0 : row_ff;
   assign x_next = CW'(x) + CW'(1);
   assign wrap = x_next >= cfg.width;
   assign y_next = {1'b0, y} + 17'd1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = wrap ? '0 : XW'(x_next);
         row_in = y;
         if (wrap) begin
            row_in = (y_next >= {1'b0, cfg.height}) ? '0 : y_next[15:0];
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         pix[8*ch +: 8] = (3'(ch) < cfg.chans) ? req_pixel[8*ch +: 8] : 8'd0;
      end
   end

   assign kind[K_NORM_PREV] = s1_xge1_ff && s1_yge1_ff;
   assign kind[K_LAST_PREV] = s1_xge1_ff && s1_last_ff;
   assign kind[K_NORM_HERE] = s1_xlast_ff && s1_yge1_ff;
   assign kind[K_LAST_HERE] = s1_xlast_ff && s1_last_ff;

   assign s1_adv = s1_valid_ff && ((kind == 4'd0) || q_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign wr_data = {s1_pix_ff, rd_ff[2*PIX_W-1:PIX_W]};

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2][0] = rd_ff[PIX_W-1:0];
      win_in[2][1] = rd_ff[2*PIX_W-1:PIX_W];
      win_in[2][2] = s1_pix_ff;
   end

   assign q_valid = s1_valid_ff && (kind != 4'd0);
   assign q_job.win = win_in;
   assign q_job.kind = kind;
   assign q_job.y_ge2 = s1_yge2_ff;
   assign q_job.x_eq1 = s1_xeq1_ff;
   assign q_job.x_eq0 = !s1_xge1_ff;
   assign q_job.h_one = s1_hone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_x_ff] <= wr_data;
         win_ff <= win_in;
      end
      if (accept) begin
         rd_ff <= (s1_adv && (s1_x_ff == x)) ? wr_data : line_mem[x];
         s1_x_ff <= x;
         s1_pix_ff <= pix;
         s1_yge1_ff <= y != 16'd0;
         s1_yge2_ff <= y >= 16'd2;
         s1_last_ff <= y == (cfg.height - 16'd1);
         s1_xge1_ff <= x != '0;
         s1_xeq1_ff <= x == XW'(1);
         s1_xlast_ff <= CW'(x) == (cfg.width - CW'(1));
         s1_hone_ff <= cfg.height == 16'd1;
      end
   end

endmodule

### rtl/wfl_queue.sv
// ----------------------------------------------------------------------------
// wfl_queue
// Two-entry queue of classified window jobs between front and back.
// ----------------------------------------------------------------------------
module wfl_queue import wfl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_pop,
   output job_type out_job
);

   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign in_ready = count_ff != 2'd2;
   assign push = in_valid && in_ready;
   assign out_valid = count_ff != 2'd0;
   assign out_job = slot_ff[rd_ff];
   assign count_in = count_ff + 2'(push) - 2'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (out_pop) rd_ff <= !rd_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_job;
   end

endmodule

### rtl/wfl_back.sv
// ----------------------------------------------------------------------------
// wfl_back
// Expands each job into its results; sharpen or blur kernel, alpha kept as is.
// ----------------------------------------------------------------------------
module wfl_back import wfl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    head_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output logic [7:0] rsp_result_0,
   output logic [7:0] rsp_result_1,
   output logic [7:0] rsp_result_2,
   output logic [7:0] rsp_result_3,
   output logic    rsp_run_last,
   output logic    rsp_frame_last
);

`include "window_3x3_sharpen_blur_filter_assert.svh"

   logic [3:0] done_ff, done_in, avail, pick, rest;
   logic       load, is_last, is_here, run_last;
   logic [2:0][1:0] ridx, cidx;
   logic [2:0][2:0][PIX_W-1:0] smp;
   logic [NUM_CH-1:0][7:0] res;

   logic       rsp_valid_ff;
   logic [NUM_CH-1:0][7:0] res_ff;
   logic       run_last_ff, frame_last_ff;

   assign avail = head_job.kind & ~done_ff;
   assign pick = avail & (~avail + 4'd1);
   assign rest = avail & ~pick;
   assign run_last = rest == 4'd0;
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign head_pop = load && run_last;
   assign done_in = head_pop ? 4'd0 : (load ? (done_ff | pick) : done_ff);

   assign is_last = pick[K_LAST_PREV] || pick[K_LAST_HERE];
   assign is_here = pick[K_NORM_HERE] || pick[K_LAST_HERE];

   always_comb begin
      if (is_last) begin
         ridx[0] = head_job.h_one ? 2'd2 : 2'd1;
         ridx[1] = 2'd2;
      end else begin
         ridx[0] = head_job.y_ge2 ? 2'd0 : 2'd1;
         ridx[1] = 2'd1;
      end
      ridx[2] = 2'd2;
      if (is_here) begin
         cidx[0] = head_job.x_eq0 ? 2'd2 : 2'd1;
         cidx[1] = 2'd2;
      end else begin
         cidx[0] = head_job.x_eq1 ? 2'd1 : 2'd0;
         cidx[1] = 2'd1;
      end
      cidx[2] = 2'd2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            smp[r][c] = head_job.win[cidx[c]][ridx[r]];
         end
      end
   end

   always_comb begin
      logic [7:0]         cen;
      logic signed [12:0] sh;
      logic [11:0]        sum;
      logic [25:0]        prod;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         cen = smp[1][1][8*ch +: 8];
         sh = $signed({5'd0, cen} + {3'd0, cen, 2'b00})
            - $signed({5'd0, smp[0][1][8*ch +: 8]})
            - $signed({5'd0, smp[2][1][8*ch +: 8]})
            - $signed({5'd0, smp[1][0][8*ch +: 8]})
            - $signed({5'd0, smp[1][2][8*ch +: 8]});
         sum = '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               sum = sum + {4'd0, smp[r][c][8*ch +: 8]};
            end
         end
         prod = 26'(sum) * 26'(BLUR_RECIP);
         if (3'(ch) >= cfg.chans) begin
            res[ch] = 8'd0;
         end else if ((cfg.chans == 3'(NUM_CH)) && (ch == ALPHA_CH)) begin
            res[ch] = cen;
         end else if (cfg.mode == FILTER_BLUR) begin
            res[ch] = prod[23:16];
         end else if (sh < 0) begin
            res[ch] = 8'd0;
         end else if (sh > 13'sd255) begin
            res[ch] = 8'd255;
         end else begin
            res[ch] = sh[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
         run_last_ff <= run_last;
         frame_last_ff <= pick[K_LAST_HERE];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_0 = res_ff[0];
   assign rsp_result_1 = res_ff[1];
   assign rsp_result_2 = res_ff[2];
   assign rsp_result_3 = res_ff[3];
   assign rsp_run_last = run_last_ff;
   assign rsp_frame_last = frame_last_ff;

   `WFL_ASSERT_SAME(a_pick_onehot, head_valid, $onehot(pick))
   `WFL_ASSERT_SAME(a_frame_last_ends_run, rsp_valid_ff && frame_last_ff, run_last_ff)
   `WFL_ASSERT_NEXT(a_head_kept, head_valid && !head_pop, head_valid)

endmodule

### rtl/window_3x3_sharpen_blur_filter.sv
// ----------------------------------------------------------------------------
// window_3x3_sharpen_blur_filter
// 3x3 sharpen or box-blur filter on a raster pixel stream, edge clamped.
//
//   port group  direction  carries
//   req_*       in         one pixel: frame_start, sample_0..3
//   rsp_*       out        one filtered pixel: result_0..3, run_last, frame_last
//   csr_*       in         register write: index, data
//
// One pixel a cycle enters while the job queue has room. A pixel that ends a
// row, or any pixel of the last row, releases up to four results, emitted on
// consecutive cycles while rsp_ready is high; the two-entry job queue absorbs
// them and the input stalls only while that queue is full. Line buffer reads
// are registered: a pixel passes the front-end stage register, a queue slot
// and the back-end result register. Reset is synchronous; registers return
// to 640 x 480, three channels, sharpen.
// ----------------------------------------------------------------------------
module window_3x3_sharpen_blur_filter import wfl_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_frame_start,
   input  logic [7:0]  req_sample_0,
   input  logic [7:0]  req_sample_1,
   input  logic [7:0]  req_sample_2,
   input  logic [7:0]  req_sample_3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_result_0,
   output logic [7:0]  rsp_result_1,
   output logic [7:0]  rsp_result_2,
   output logic [7:0]  rsp_result_3,
   output logic        rsp_run_last,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [11:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  chans_ff;
   logic        mode_ff;
   cfg_type     cfg;
   logic        q_in_valid, q_in_ready, q_out_valid, q_pop;
   job_type     q_in_job, q_out_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 12'd640;
         height_ff <= 16'd480;
         chans_ff <= 3'd3;
         mode_ff <= FILTER_SHARPEN;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff <= csr_data[11:0];
            REG_HEIGHT: height_ff <= csr_data;
            REG_CHANS:  chans_ff <= csr_data[2:0];
            REG_MODE:   mode_ff <= csr_data[0];
            default:    mode_ff <= mode_ff;
         endcase
      end
   end

   always_comb begin
      cfg.width = CW'(width_ff);
      if (width_ff == 12'd0) begin
         cfg.width = CW'(1);
      end else if (CW'(width_ff) > CW'(MAX_WIDTH)) begin
         cfg.width = CW'(MAX_WIDTH);
      end
      cfg.height = (height_ff == 16'd0) ? 16'd1 : height_ff;
      cfg.chans = chans_ff;
      if (chans_ff == 3'd0) begin
         cfg.chans = 3'd1;
      end else if (chans_ff > 3'(MAX_CHANNELS)) begin
         cfg.chans = 3'(MAX_CHANNELS);
      end
      cfg.mode = mode_ff;
   end

   wfl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame_start (req_frame_start),
      .req_pixel       ({req_sample_3, req_sample_2, req_sample_1, req_sample_0}),
      .q_valid         (q_in_valid),
      .q_ready         (q_in_ready),
      .q_job           (q_in_job)
   );

   wfl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_job    (q_in_job),
      .out_valid (q_out_valid),
      .out_pop   (q_pop),
      .out_job   (q_out_job)
   );

   wfl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head_valid     (q_out_valid),
      .head_job       (q_out_job),
      .head_pop       (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_0   (rsp_result_0),
      .rsp_result_1   (rsp_result_1),
      .rsp_result_2   (rsp_result_2),
      .rsp_result_3   (rsp_result_3),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

### verif/tb_window_3x3_sharpen_blur_filter.sv
// ----------------------------------------------------------------------------
// tb_window_3x3_sharpen_blur_filter
// Self-checking bench for the 3x3 sharpen / box-blur window filter.
// A behavioral filter tracks line buffers, window and position per accepted
// request and queues the filtered pixels; each result is compared field by
// field. Covers register extremes, out-of-range registers, edge clamping,
// frame wrap, an over-wide row setting and random frames with back-pressure.
// ----------------------------------------------------------------------------
module tb_window_3x3_sharpen_blur_filter import wfl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 2048;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [3:0][7:0] chan;
      logic            run_last;
      logic            frame_last;
   } filtered_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_frame_start = 1'b0;
   logic [7:0]  req_sample_0 = '0;
   logic [7:0]  req_sample_1 = '0;
   logic [7:0]  req_sample_2 = '0;
   logic [7:0]  req_sample_3 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_result_0;
   logic [7:0]  rsp_result_1;
   logic [7:0]  rsp_result_2;
   logic [7:0]  rsp_result_3;
   logic        rsp_run_last;
   logic        rsp_frame_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   window_3x3_sharpen_blur_filter dut (.*);

   // filter state mirror
   logic [31:0] upper_mem [LINE_DEPTH];
   logic [31:0] middle_mem [LINE_DEPTH];
   logic [7:0]  win [3][3][4];
   int unsigned col_pos, row_pos;
   logic [11:0] cfg_width = 12'd640;
   logic [15:0] cfg_height = 16'd480;
   logic [2:0]  cfg_chans = 3'd3;
   logic        cfg_mode = FILTER_SHARPEN;

   filtered_pixel_type pending_pixels [$];
   int mismatch_count = 0;
   int pixels_checked = 0;
   int requests_sent = 0;
   int unsigned cycle_count = 0;
   bit req_gaps = 1'b1;
   bit rsp_stalls = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d (pixel %0d)", what, got, want, pixels_checked);
      mismatch_count++;
   endtask

   function automatic filtered_pixel_type apply_kernel(input int rows[3], input int cols[3],
                                                        input int chans, input bit flast);
      filtered_pixel_type p;
      int s;
      p = '0;
      for (int ch = 0; ch < 4; ch++) begin
         s = 0;
         if (ch < chans) begin
            if (chans == 4 && ch == ALPHA_CH) begin
               s = win[cols[1]][rows[1]][ch];
            end else if (cfg_mode == FILTER_BLUR) begin
               for (int r = 0; r < 3; r++)
                  for (int c = 0; c < 3; c++)
                     s += win[cols[c]][rows[r]][ch];
               s = s / 9;
            end else begin
               s = 5 * win[cols[1]][rows[1]][ch] - win[cols[1]][rows[0]][ch]
                   - win[cols[1]][rows[2]][ch] - win[cols[0]][rows[1]][ch]
                   - win[cols[2]][rows[1]][ch];
               if (s < 0) s = 0;
               if (s > 255) s = 255;
            end
         end
         p.chan[ch] = s[7:0];
      end
      p.frame_last = flast;
      return p;
   endfunction

   task automatic advance_pixel(input bit fs, input logic [3:0][7:0] samples);
      int unsigned w, h, chans, x, y;
      logic [31:0] packed_in;
      int rows_norm[3], rows_last[3], cols_prev[3], cols_here[3];
      filtered_pixel_type released [$];
      bit last_row;
      w = (cfg_width == 0) ? 1 : (cfg_width > LINE_DEPTH) ? LINE_DEPTH : cfg_width;
      h = (cfg_height == 0) ? 1 : cfg_height;
      chans = (cfg_chans == 0) ? 1 : (cfg_chans > NUM_CH) ? NUM_CH : cfg_chans;
      if (fs || col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      packed_in = '0;
      for (int ch = 0; ch < chans; ch++) packed_in[8*ch +: 8] = samples[ch];
      win[0] = win[1];
      win[1] = win[2];
      for (int ch = 0; ch < 4; ch++) begin
         win[2][0][ch] = upper_mem[x][8*ch +: 8];
         win[2][1][ch] = middle_mem[x][8*ch +: 8];
         win[2][2][ch] = packed_in[8*ch +: 8];
      end
      upper_mem[x] = middle_mem[x];
      middle_mem[x] = packed_in;
      last_row = (y == h - 1);
      rows_norm = '{(y >= 2) ? 0 : 1, 1, 2};
      if (h == 1) begin
         rows_last = '{2, 2, 2};
      end else begin
         rows_last = '{1, 2, 2};
      end
      cols_prev = '{(x == 1) ? 1 : 0, 1, 2};
      cols_here = '{(x == 0) ? 2 : 1, 2, 2};
      if (x >= 1) begin
         if (y >= 1) released.push_back(apply_kernel(rows_norm, cols_prev, chans, 0));
         if (last_row) released.push_back(apply_kernel(rows_last, cols_prev, chans, 0));
      end
      if (x == w - 1) begin
         if (y >= 1) released.push_back(apply_kernel(rows_norm, cols_here, chans, 0));
         if (last_row) released.push_back(apply_kernel(rows_last, cols_here, chans, 1));
      end
      if (released.size() > 0) released[released.size()-1].run_last = 1'b1;
      foreach (released[i]) pending_pixels.push_back(released[i]);
      col_pos = x + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = y + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      filtered_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("unexpected result pixel, nothing pending");
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_result_0 !== want.chan[0]) report("result_0", rsp_result_0, want.chan[0]);
            if (rsp_result_1 !== want.chan[1]) report("result_1", rsp_result_1, want.chan[1]);
            if (rsp_result_2 !== want.chan[2]) report("result_2", rsp_result_2, want.chan[2]);
            if (rsp_result_3 !== want.chan[3]) report("result_3", rsp_result_3, want.chan[3]);
            if (rsp_run_last !== want.run_last)
               report("run_last", rsp_run_last, want.run_last);
            if (rsp_frame_last !== want.frame_last)
               report("frame_last", rsp_frame_last, want.frame_last);
         end
         pixels_checked++;
      end
   end

   // result-side back-pressure
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input bit fs, input logic [3:0][7:0] samples);
      req_valid <= 1'b1;
      req_frame_start <= fs;
      req_sample_0 <= samples[0];
      req_sample_1 <= samples[1];
      req_sample_2 <= samples[2];
      req_sample_3 <= samples[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_pixel(fs, samples);
      requests_sent++;
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_random(input bit fs);
      send_pixel(fs, {pick_sample(), pick_sample(), pick_sample(), pick_sample()});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_WIDTH:  cfg_width = value[11:0];
         REG_HEIGHT: cfg_height = value;
         REG_CHANS:  cfg_chans = value[2:0];
         REG_MODE:   cfg_mode = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_frame(input int w, input int h, input int chans, input bit mode);
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      write_reg(REG_CHANS, 16'(chans));
      write_reg(REG_MODE, 16'(mode));
   endtask

   task automatic test_reset_defaults();
      for (int i = 0; i < 3; i++) send_random(i == 0);
      drain();
   endtask

   task automatic test_directed_extremes();
      // single pixel frames, four channels, blur
      set_frame(1, 1, 4, FILTER_BLUR);
      send_pixel(1, {8'd255, 8'd255, 8'd255, 8'd255});
      send_pixel(0, {8'd0, 8'd0, 8'd0, 8'd0});
      drain();
      // 3x3 sharpen, saturate high and low
      set_frame(3, 3, 4, FILTER_SHARPEN);
      for (int i = 0; i < 9; i++)
         send_pixel(i == 0, (i == 4) ? {4{8'd255}} : (i % 2) ? {4{8'd255}} : {4{8'd0}});
      drain();
      // out-of-range registers: zero width, height and channels
      set_frame(0, 0, 0, FILTER_BLUR);
      send_pixel(1, {8'hA5, 8'h5A, 8'hFF, 8'h01});
      drain();
      set_frame(2, 2, 7, FILTER_BLUR);
      for (int i = 0; i < 4; i++) send_pixel(i == 0, {8'hFF, 8'h00, 8'hAA, 8'h55});
      drain();
      set_frame(2, 2, 5, FILTER_SHARPEN);
      for (int i = 0; i < 4; i++) send_random(0);
      drain();
   endtask

   task automatic test_widest_row();
      // width above the line depth acts as the full depth
      set_frame(4095, 1, 2, FILTER_SHARPEN);
      for (int i = 0; i < 64; i++) send_random(i == 0);
      drain();
   endtask

   task automatic test_tallest_frame();
      set_frame(5, 65535, 4, FILTER_BLUR);
      for (int i = 0; i < 15; i++) send_random(i == 0);
      drain();
   endtask

   task automatic test_wrap_and_reposition();
      set_frame(4, 3, 3, FILTER_SHARPEN);
      for (int i = 0; i < 24 + 6; i++) send_random(i == 0);
      drain();
      // stored column now outside the narrower frame
      write_reg(REG_WIDTH, 16'd2);
      for (int i = 0; i < 8; i++) send_random(0);
      drain();
      write_reg(REG_HEIGHT, 16'd1);
      for (int i = 0; i < 4; i++) send_random(0);
      drain();
   endtask

   task automatic test_random_frames();
      int budget;
      int w, h;
      budget = 300;
      while (budget > 0) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         set_frame(w, h, $urandom_range(0, 7), $urandom_range(0, 1));
         if (budget < 120) begin
            req_gaps = 1'b0;
            rsp_stalls = 1'b0;
         end else begin
            req_gaps = $urandom_range(0, 3) != 0;
            rsp_stalls = $urandom_range(0, 3) != 0;
         end
         for (int f = 0; f < $urandom_range(1, 3); f++) begin
            for (int i = 0; i < ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h); i++) begin
               send_random((i == 0 && f == 0) || $urandom_range(0, 40) == 0);
               budget--;
            end
         end
         if ($urandom_range(0, 2) == 0)
            for (int i = 0; i < $urandom_range(1, 5); i++) send_random(0);
         drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_extremes();
      test_tallest_frame();
      test_wrap_and_reposition();
      test_widest_row();
      test_random_frames();
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d result pixels: sharpen and blur, 1-4 channels,",
               requests_sent, pixels_checked);
      $display("width 0..4095 requested, height 0..65535, frame wrap, repositioning, stalls");
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
